// ===== src/mmbc_pkg.sv =====
package mmbc_pkg;

   // default number of fraction bits of state values, gains and command
   localparam int FRAC_BITS_DEF = 16;

   // time step is unsigned Q0.16
   localparam int DT_FRAC_BITS = 16;

   // stored integral is clamped to plus or minus this value
   localparam int INTEGRAL_LIMIT = 655360;

   // controller_mode codes
   localparam logic [1:0] MODE_FEEDBACK = 2'd0;
   localparam logic [1:0] MODE_PID      = 2'd1;
   localparam logic [1:0] MODE_POLE     = 2'd2;
   localparam logic [1:0] MODE_ZERO     = 2'd3;

   // register indexes on the csr port
   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_GAIN_POS  = 3'd1;
   localparam logic [2:0] REG_GAIN_VEL  = 3'd2;
   localparam logic [2:0] REG_GAIN_ANG  = 3'd3;
   localparam logic [2:0] REG_GAIN_RATE = 3'd4;
   localparam logic [2:0] REG_PROP      = 3'd5;
   localparam logic [2:0] REG_INTEG     = 3'd6;
   localparam logic [2:0] REG_DERIV     = 3'd7;

   // fixed pole placement gains, plain integers
   localparam logic signed [31:0] POLE_GAIN_POS  = 32'sd1;
   localparam logic signed [31:0] POLE_GAIN_VEL  = 32'sd2;
   localparam logic signed [31:0] POLE_GAIN_ANG  = 32'sd30;
   localparam logic signed [31:0] POLE_GAIN_RATE = 32'sd6;

   // multiplier operand pair codes
   localparam logic [2:0] OP_POS  = 3'd0;  // position gain times cart_position
   localparam logic [2:0] OP_VEL  = 3'd1;  // velocity gain times cart_velocity
   localparam logic [2:0] OP_ANG  = 3'd2;  // angle gain times pendulum_angle
   localparam logic [2:0] OP_RATE = 3'd3;  // rate gain times angular_rate
   localparam logic [2:0] OP_DT   = 3'd4;  // pendulum_angle times time_step
   localparam logic [2:0] OP_KP   = 3'd5;  // prop_gain times pendulum_angle
   localparam logic [2:0] OP_KI   = 3'd6;  // integ_gain times integral
   localparam logic [2:0] OP_KD   = 3'd7;  // deriv_gain times angular_rate

   // request and response payload widths
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 32;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture request, clear accumulator
      logic       mul_en;     // register one product
      logic [2:0] op;         // operand pair for the product
      logic       acc_sub;    // subtract the term instead of adding it
      logic       acc_shift;  // floor shift the product by the fraction bits
      logic       integ_upd;  // product updates the integral, not the sum
      logic       out_load;   // move saturated sum into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       out_busy;
   } status_type;

endpackage

// ===== src/mmbc_ctrl.sv =====
module mmbc_ctrl
   import mmbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               step_in  = 2'd0;
               state_in = (status.mode == MODE_ZERO) ? S_FIN : S_RUN;
            end
         end
         S_RUN: begin
            cmd.mul_en = 1'b1;
            case (status.mode)
               MODE_PID: begin
                  cmd.acc_shift = 1'b1;
                  case (step_ff)
                     2'd0: begin
                        cmd.op        = OP_DT;
                        cmd.integ_upd = 1'b1;
                     end
                     2'd1: cmd.op = OP_KP;
                     2'd2: cmd.op = OP_KI;
                     default: cmd.op = OP_KD;
                  endcase
               end
               default: begin
                  // feedback and fixed pole: negated sum of four products
                  cmd.acc_sub   = 1'b1;
                  cmd.acc_shift = (status.mode == MODE_FEEDBACK);
                  case (step_ff)
                     2'd0: cmd.op = OP_POS;
                     2'd1: cmd.op = OP_VEL;
                     2'd2: cmd.op = OP_ANG;
                     default: cmd.op = OP_RATE;
                  endcase
               end
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last product is summed on this edge
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("result loaded over an unread result");

   a_run_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && step_ff == 2'd3) |=> (state_ff == S_DRAIN))
      else $error("product sequence did not end after four steps");

   a_zero_mode_skips: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.mode == MODE_ZERO) |=> (state_ff == S_FIN))
      else $error("output zero mode ran the multiplier");

endmodule

// ===== src/mmbc_dpath.sv =====
module mmbc_dpath
   import mmbc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // terms are at most 2^(62-FRAC_BITS) in size, four of them summed
   localparam int AW = 66 - FRAC_BITS;
   localparam logic signed [AW-1:0] SAT_MAX = AW'(32'sh7fff_ffff);
   localparam logic signed [AW-1:0] SAT_MIN = AW'(signed'(32'h8000_0000));
   localparam logic signed [33:0]   LIM_POS = 34'(INTEGRAL_LIMIT);
   localparam logic signed [33:0]   LIM_NEG = -LIM_POS;

   // configuration
   logic [1:0]         mode_ff;
   logic signed [31:0] gain_pos_ff, gain_vel_ff, gain_ang_ff, gain_rate_ff;
   logic signed [31:0] prop_ff, integ_gain_ff, deriv_ff;
   logic signed [31:0] integral_ff;

   // captured request
   logic signed [31:0] pos_ff, vel_ff, ang_ff, rate_ff;
   logic [15:0]        dt_ff;

   // product stage with its summing tags
   logic signed [31:0] op_a, op_b;
   logic signed [63:0] mul_out;
   logic signed [63:0] prod_ff;
   logic               pend_acc_ff, pend_sub_ff, pend_shift_ff, pend_integ_ff;

   logic signed [63:0] term;
   logic signed [AW-1:0] term_w;
   logic signed [AW-1:0] acc_ff, acc_in;

   logic signed [31:0] inc;
   logic signed [33:0] integ_sum;
   logic signed [31:0] integ_clamped;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic [31:0]        sat_val;

   assign status.mode     = mode_ff;
   assign status.out_busy = rsp_valid_ff & ~rsp_tready;

   // operand selection for the shared multiplier
   always_comb begin
      case (cmd.op)
         OP_POS: begin
            op_a = (mode_ff == MODE_POLE) ? POLE_GAIN_POS : gain_pos_ff;
            op_b = pos_ff;
         end
         OP_VEL: begin
            op_a = (mode_ff == MODE_POLE) ? POLE_GAIN_VEL : gain_vel_ff;
            op_b = vel_ff;
         end
         OP_ANG: begin
            op_a = (mode_ff == MODE_POLE) ? POLE_GAIN_ANG : gain_ang_ff;
            op_b = ang_ff;
         end
         OP_RATE: begin
            op_a = (mode_ff == MODE_POLE) ? POLE_GAIN_RATE : gain_rate_ff;
            op_b = rate_ff;
         end
         OP_DT: begin
            op_a = ang_ff;
            op_b = signed'({16'd0, dt_ff});
         end
         OP_KP: begin
            op_a = prop_ff;
            op_b = ang_ff;
         end
         OP_KI: begin
            op_a = integ_gain_ff;
            op_b = integral_ff;
         end
         OP_KD: begin
            op_a = deriv_ff;
            op_b = rate_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mul_out = op_a * op_b;

   // floor shift of the registered product
   assign term   = pend_shift_ff ? (prod_ff >>> FRAC_BITS) : prod_ff;
   assign term_w = signed'(term[AW-1:0]);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (pend_acc_ff) begin
         acc_in = pend_sub_ff ? (acc_ff - term_w) : (acc_ff + term_w);
      end
   end

   // integral step: floor(angle * dt / 2^16), added and clamped
   assign inc       = signed'(prod_ff[DT_FRAC_BITS+31:DT_FRAC_BITS]);
   assign integ_sum = 34'(integral_ff) + 34'(inc);

   always_comb begin
      if (integ_sum > LIM_POS) begin
         integ_clamped = 32'(LIM_POS);
      end else if (integ_sum < LIM_NEG) begin
         integ_clamped = 32'(LIM_NEG);
      end else begin
         integ_clamped = integ_sum[31:0];
      end
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         sat_val = 32'h7fff_ffff;
      end else if (acc_ff < SAT_MIN) begin
         sat_val = 32'h8000_0000;
      end else begin
         sat_val = acc_ff[31:0];
      end
   end

   // configuration registers and integral
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FEEDBACK;
         gain_pos_ff   <= '0;
         gain_vel_ff   <= '0;
         gain_ang_ff   <= '0;
         gain_rate_ff  <= '0;
         prop_ff       <= '0;
         integ_gain_ff <= '0;
         deriv_ff      <= '0;
         integral_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_MODE: begin
                  mode_ff     <= csr_data[1:0];
                  integral_ff <= '0;
               end
               REG_GAIN_POS:  gain_pos_ff   <= csr_data;
               REG_GAIN_VEL:  gain_vel_ff   <= csr_data;
               REG_GAIN_ANG:  gain_ang_ff   <= csr_data;
               REG_GAIN_RATE: gain_rate_ff  <= csr_data;
               REG_PROP:      prop_ff       <= csr_data;
               REG_INTEG:     integ_gain_ff <= csr_data;
               REG_DERIV:     deriv_ff      <= csr_data;
               default: begin
               end
            endcase
         end else if (pend_integ_ff) begin
            integral_ff <= integ_clamped;
         end
      end
   end

   // request capture and product register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff  <= req_tdata[31:0];
         vel_ff  <= req_tdata[63:32];
         ang_ff  <= req_tdata[95:64];
         rate_ff <= req_tdata[127:96];
         dt_ff   <= req_tdata[143:128];
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_out;
      end
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         rsp_data_ff <= sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_acc_ff   <= 1'b0;
         pend_sub_ff   <= 1'b0;
         pend_shift_ff <= 1'b0;
         pend_integ_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_acc_ff   <= cmd.mul_en & ~cmd.integ_upd;
         pend_sub_ff   <= cmd.acc_sub;
         pend_shift_ff <= cmd.acc_shift;
         pend_integ_ff <= cmd.mul_en & cmd.integ_upd;
         rsp_valid_ff  <= cmd.out_load | (rsp_valid_ff & ~rsp_tready);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (integral_ff <= 32'(LIM_POS)) && (integral_ff >= 32'(LIM_NEG)))
      else $error("integral outside its clamp");

   a_integ_only_pid: assert property (@(posedge clock) disable iff (reset)
      pend_integ_ff |-> (mode_ff == MODE_PID))
      else $error("integral updated outside pid mode");

endmodule

// ===== src/multi_mode_balance_controller.sv =====
// channel   direction  handshake                    payload
// req       in         req_tvalid / req_tready      pendulum state and time step
// rsp       out        rsp_tvalid / rsp_tready      velocity command
// csr       in         csr_valid / csr_ready        register index and write data
//
// a request runs through a capture step, four products on the single shared 32x32
// multiplier, a step to sum the last product and a step to load the output register,
// which waits while an unread result holds it; no new request is taken until the load
// output zero mode skips the multiplier and goes from capture straight to the load
// reset is synchronous and active high; it clears the sequencer, the gains, the
// mode, the integral and the output valid flag, and no clearing pass follows
// a result waiting on rsp_tready does not block the next request; only a
// second finished result waits for the output register to free up
module multi_mode_balance_controller
   import mmbc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cart_position, cart_velocity, pendulum_angle, angular_rate, time_step
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // velocity_command
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   cmd_type    cmd;
   status_type status;

   // writes are to arrive only while idle, which the block does not check; they are always taken
   assign csr_ready = 1'b1;

   // sequencer: request handshake and product schedule per mode
   mmbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // registers, shared multiplier, accumulator, integral and output register
   mmbc_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mmbc_pkg::*;

   // pendulum state packed as on req_tdata, cart_position in the lowest bits
   typedef struct packed {
      logic [15:0]        time_step;
      logic signed [31:0] angular_rate;
      logic signed [31:0] pendulum_angle;
      logic signed [31:0] cart_velocity;
      logic signed [31:0] cart_position;
   } pend_state_type;

   // generous bound on the whole run, several times the slowest legal run
   localparam int CYCLE_LIMIT = 250000;
   // cycles that pass after the last result before the block counts as idle
   localparam int SETTLE_CYCLES = 12;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // cart_position, cart_velocity, pendulum_angle, angular_rate, time_step
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // velocity_command
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [2:0]            csr_index = '0;
   logic [31:0]           csr_data = '0;

   // shadow copy of the controller registers and the stored integral
   logic [1:0]         ctrl_mode = MODE_FEEDBACK;
   logic signed [31:0] gain_reg [8] = '{default: '0};
   logic signed [31:0] angle_integral = '0;

   // commands predicted for accepted requests, oldest first
   logic [31:0] expected_commands [$];

   int error_count = 0;
   int cycle_count = 0;
   // idle and stall odds in percent, set per phase
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   // long receiver hold-off, counted down by the ready process
   int rsp_hold_cycles = 0;

   multi_mode_balance_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_mode_balance_controller regression: fail");
         $finish;
      end
   end

   // receiver: long hold-off first, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare every accepted command with the oldest prediction
   always @(posedge clock) begin : check_commands
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_commands.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected velocity_command %h", rsp_tdata);
         end else begin
            want = expected_commands.pop_front();
            if (rsp_tdata !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("velocity_command mismatch: expected %h actual %h", want, rsp_tdata);
            end
         end
      end
   end

   // gain times value, exact, then floored by the given shift
   function automatic logic signed [63:0] scaled_product(input logic signed [31:0] gain,
                                                         input logic signed [31:0] value,
                                                         input int shift);
      logic signed [63:0] g64;
      logic signed [63:0] v64;
      g64 = 64'(gain);
      v64 = 64'(value);
      return (g64 * v64) >>> shift;
   endfunction

   // command for one accepted request; updates the shadow integral in pid mode
   function automatic logic [31:0] compute_command(input pend_state_type s);
      logic signed [63:0] total;
      logic signed [63:0] acc;
      logic signed [63:0] ang64;
      logic signed [63:0] dt64;
      total = '0;
      case (ctrl_mode)
         MODE_FEEDBACK: begin
            total = -(scaled_product(gain_reg[REG_GAIN_POS], s.cart_position, FRAC_BITS_DEF)
                    + scaled_product(gain_reg[REG_GAIN_VEL], s.cart_velocity, FRAC_BITS_DEF)
                    + scaled_product(gain_reg[REG_GAIN_ANG], s.pendulum_angle, FRAC_BITS_DEF)
                    + scaled_product(gain_reg[REG_GAIN_RATE], s.angular_rate, FRAC_BITS_DEF));
         end
         MODE_PID: begin
            ang64 = 64'(s.pendulum_angle);
            dt64 = {48'd0, s.time_step};
            acc = 64'(angle_integral) + ((ang64 * dt64) >>> DT_FRAC_BITS);
            // integral clamps before it feeds the integral term
            if (acc > 64'(INTEGRAL_LIMIT))
               acc = 64'(INTEGRAL_LIMIT);
            else if (acc < -64'(INTEGRAL_LIMIT))
               acc = -64'(INTEGRAL_LIMIT);
            angle_integral = acc[31:0];
            total = scaled_product(gain_reg[REG_PROP], s.pendulum_angle, FRAC_BITS_DEF)
                  + scaled_product(gain_reg[REG_INTEG], angle_integral, FRAC_BITS_DEF)
                  + scaled_product(gain_reg[REG_DERIV], s.angular_rate, FRAC_BITS_DEF);
         end
         MODE_POLE: begin
            // plain integer gains, no fraction shift
            total = -(scaled_product(POLE_GAIN_POS, s.cart_position, 0)
                    + scaled_product(POLE_GAIN_VEL, s.cart_velocity, 0)
                    + scaled_product(POLE_GAIN_ANG, s.pendulum_angle, 0)
                    + scaled_product(POLE_GAIN_RATE, s.angular_rate, 0));
         end
         default: total = '0;
      endcase
      if (total > 64'sd2147483647)
         return 32'h7FFF_FFFF;
      if (total < -64'sd2147483648)
         return 32'h8000_0000;
      return total[31:0];
   endfunction

   function automatic pend_state_type pack_state(input logic signed [31:0] pos,
                                                 input logic signed [31:0] vel,
                                                 input logic signed [31:0] ang,
                                                 input logic signed [31:0] rate,
                                                 input logic [15:0] dt);
      pend_state_type s;
      s.cart_position  = pos;
      s.cart_velocity  = vel;
      s.pendulum_angle = ang;
      s.angular_rate   = rate;
      s.time_step      = dt;
      return s;
   endfunction

   // mix of extremes, small values around zero and full range
   function automatic logic signed [31:0] rand_fixed();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         4, 5, 6: return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
         default: return $urandom();
      endcase
   endfunction

   function automatic pend_state_type rand_state();
      logic [15:0] dt;
      case ($urandom_range(7))
         0: dt = '0;
         1: dt = 16'hFFFF;
         2, 3: dt = 16'($urandom());
         default: dt = 16'($urandom_range(0, 16'h0FFF));  // short control periods
      endcase
      return pack_state(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(), dt);
   endfunction

   // one request: optional idle gap, then hold valid until accepted
   task automatic send_state(input pend_state_type s);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(99) < req_idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      expected_commands.push_back(compute_command(s));
   endtask

   // stop sending, wait for every command, then let the pipeline settle
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_commands.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; only called while the block is idle
   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // any mode write clears the integral, gain writes leave it alone
      if (index == REG_MODE) begin
         ctrl_mode = data[1:0];
         angle_integral = '0;
      end else begin
         gain_reg[index] = data;
      end
      @(posedge clock);
   endtask

   // mode with random upper bits that the block must mask off, then all gains
   task automatic load_random_settings(input logic [1:0] mode);
      write_reg(REG_MODE, {30'($urandom()), mode});
      for (int r = int'(REG_GAIN_POS); r <= int'(REG_DERIV); r++)
         write_reg(3'(r), rand_fixed());
   endtask

   task automatic test_state_feedback();
      wait_results_done();
      write_reg(REG_MODE, {30'd0, MODE_FEEDBACK});
      for (int r = int'(REG_GAIN_POS); r <= int'(REG_GAIN_RATE); r++)
         write_reg(3'(r), 32'h7FFF_FFFF);
      // full scale both ways saturates high and low
      send_state(pack_state(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 16'hFFFF));
      send_state(pack_state(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 16'h0000));
      wait_results_done();
      write_reg(REG_GAIN_POS, 32'h0001_0000);   // 1.0
      write_reg(REG_GAIN_VEL, 32'hFFFE_0000);   // -2.0
      write_reg(REG_GAIN_ANG, 32'h0000_4000);   // 0.25
      write_reg(REG_GAIN_RATE, 32'h8000_0000);  // most negative gain
      // one lsb values check floor rounding of negative products
      send_state(pack_state(32'sh0001_8000, -32'sd1, -32'sd1, 32'sd1, 16'h1234));
      send_state(pack_state('0, '0, '0, '0, '0));
   endtask

   task automatic test_pid_integral();
      wait_results_done();
      write_reg(REG_MODE, {30'd0, MODE_PID});
      write_reg(REG_PROP, 32'h0001_0000);
      write_reg(REG_INTEG, 32'h0001_0000);
      write_reg(REG_DERIV, 32'hFFFF_8000);
      // angle 8.0 over half a second, three times: walks up into the clamp
      repeat (3)
         send_state(pack_state(rand_fixed(), rand_fixed(), 32'sh0008_0000,
                               32'sh0001_0000, 16'h8000));
      // hard negative step drives it to the lower clamp
      send_state(pack_state('0, '0, 32'sh8000_0000, '0, 16'hFFFF));
      // zero time step leaves the integral where it is
      send_state(pack_state('0, '0, 32'sh0003_0000, 32'sh0002_0000, 16'h0000));
      wait_results_done();
      // gain write keeps the integral
      write_reg(REG_INTEG, 32'h7FFF_FFFF);
      send_state(pack_state('0, '0, 32'sh0001_0000, '0, 16'h0000));
      wait_results_done();
      // rewriting the same mode clears the integral
      write_reg(REG_MODE, {30'd0, MODE_PID});
      send_state(pack_state('0, '0, 32'sh0002_0000, '0, 16'h4000));
      wait_results_done();
      write_reg(REG_PROP, 32'h8000_0000);
      write_reg(REG_DERIV, 32'h7FFF_FFFF);
      send_state(pack_state('0, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF));
   endtask

   task automatic test_fixed_poles();
      wait_results_done();
      write_reg(REG_MODE, {30'd0, MODE_POLE});
      send_state(pack_state(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 16'hFFFF));
      send_state(pack_state(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 16'h0000));
      send_state(pack_state(32'sd1, -32'sd1, 32'sd3, -32'sd5, 16'h0100));
   endtask

   task automatic test_output_zero();
      wait_results_done();
      // upper data bits set, only the low two reach the mode
      write_reg(REG_MODE, {30'h3FFF_FFFF, MODE_ZERO});
      send_state(pack_state(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 16'hFFFF));
      send_state(rand_state());
   endtask

   // receiver holds off while the sender keeps offering, then the sender drains
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_results_done();
      load_random_settings(MODE_PID);
      rsp_hold_cycles = 300;
      repeat (16) send_state(rand_state());
      wait_results_done();
      repeat (8) send_state(rand_state());
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      logic [1:0] mode_order [4];
      mode_order = '{MODE_FEEDBACK, MODE_PID, MODE_POLE, MODE_ZERO};
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int seg = 0; seg < 4; seg++) begin
         wait_results_done();
         load_random_settings(mode_order[seg]);
         repeat (26) send_state(rand_state());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0);
      run_random_phase(62, 0);
      run_random_phase(0, 62);
      run_random_phase(23, 23);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_state_feedback();
      test_pid_integral();
      test_fixed_poles();
      test_output_zero();
      test_backpressure();
      test_random_traffic();
      wait_results_done();
      // predictions never answered count as failures
      error_count += expected_commands.size();
      if (error_count == 0)
         $display("multi_mode_balance_controller regression: pass");
      else
         $display("multi_mode_balance_controller regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
src/mmbc_pkg.sv
src/mmbc_ctrl.sv
src/mmbc_dpath.sv
src/multi_mode_balance_controller.sv
test/tb_top.sv
